/* hdl/lpm_pkg.sv */
// Lens phase mask generator package: widths, register indexes, transfer types
// and the CORDIC arc-tangent table.
// No dependencies.
`default_nettype none

package lpm_pkg;

    localparam int MAX_DIM       = 4096;
    localparam int DIM_W         = 13;
    localparam int COORD_W       = 12;
    localparam int ANGLE_BITS    = 16;
    localparam int OUT_FRAC_BITS = 14;
    localparam int OUT_W         = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 30;
    localparam int PITCH_W    = 17;
    localparam int LAMBDA_W   = 15;
    localparam int FOCAL_W    = 30;

    // tile reduction: restoring remainder, three bits per stage
    localparam int MOD_STAGES = 4;
    localparam int MOD_BITS   = COORD_W / MOD_STAGES;

    localparam int OFS_W = COORD_W + 2;
    localparam int DX_W  = 31;
    localparam int R2_W  = 60;
    localparam int F2_W  = 2 * FOCAL_W;

    // square root: floor(sqrt(n) * 2^SQRT_FRAC)
    localparam int SQRT_FRAC = ANGLE_BITS + 4;
    localparam int N_W       = 62;
    localparam int ROOT_W    = N_W / 2 + SQRT_FRAC;
    localparam int SQ_STEPS  = ROOT_W;
    localparam int SQ_REM_W  = ROOT_W + 3;

    // fractional division: low Q_W quotient bits of (num << Q_W) / den
    localparam int Q_W       = ANGLE_BITS + 1;
    localparam int NUM_W     = R2_W + Q_W;
    localparam int DIV_STEPS = NUM_W;
    localparam int DEN_W     = FOCAL_W + LAMBDA_W + 1;

    localparam int CORDIC_STEPS = 28;
    localparam int CW           = 34;
    localparam int ZW           = 32;
    localparam logic signed [CW-1:0] CORDIC_GAIN_INV = 34'sh0_26DD_3B6A;

    localparam logic [ZW-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EXACT_MODE   = 3'd0,
        REG_TILED_MODE   = 3'd1,
        REG_FRAME_WIDTH  = 3'd2,
        REG_FRAME_HEIGHT = 3'd3,
        REG_TILE_SIZE    = 3'd4,
        REG_PIXEL_PITCH  = 3'd5,
        REG_WAVELENGTH   = 3'd6,
        REG_FOCAL_LENGTH = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
    } item_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] real_part;
        logic signed [OUT_W-1:0] imag_part;
        logic                    index_error;
    } result_t;

endpackage

`default_nettype wire

/* hdl/lens_phase_mask_generator.sv */
// Lens phase mask generator top level: coordinate reduction, radius, square
// root, fractional division and CORDIC, all as one stalling pipeline.
// Depends on lpm_pkg.
`default_nettype none

// Takes one pixel (row, col) per transfer and returns cos/sin of the thin-lens
// phase at that pixel, scaled by 2^14, one result per item. A new item can be
// taken every cycle while the result is not stalled; each item passes through
// the 51-step square root and the 77-step fractional divider, each one step
// per stage. A stalled result holds the whole pipeline. Pixels outside the
// frame give index_error with zero parts. Configuration changes take effect
// for items sent after the write.
module lens_phase_mask_generator
    import lpm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  wr_en,
    input  wire logic [CFG_IDX_W-1:0]  wr_index,
    input  wire logic [CFG_DATA_W-1:0] wr_data,
    input  wire logic                  item_valid,
    output logic                       item_stall,
    input  wire item_t                 item,
    output logic                       result_valid,
    input  wire logic                  result_stall,
    output result_t                    result
);

    localparam logic signed [CW-1:0] ROUND_HALF = CW'(1) <<< (29 - OUT_FRAC_BITS);
    localparam logic signed [CW-1:0] OUT_LIM    = CW'(1) <<< OUT_FRAC_BITS;

    // configuration
    logic                 exact_mode_reg;
    logic                 tiled_mode_reg;
    logic [DIM_W-1:0]     frame_width_reg;
    logic [DIM_W-1:0]     frame_height_reg;
    logic [DIM_W-1:0]     tile_size_reg;
    logic [PITCH_W-1:0]   pitch_reg;
    logic [LAMBDA_W-1:0]  lambda_reg;
    logic [FOCAL_W-1:0]   focal_reg;
    logic [F2_W-1:0]      f2_reg;
    logic [F2_W-1:0]      f2_next;
    logic [DEN_W-1:0]     fl2_reg;
    logic [DEN_W-2:0]     fl_prod;

    logic [DIM_W-1:0]     width_c;
    logic [DIM_W-1:0]     height_c;
    logic [DIM_W-1:0]     tile_c;
    logic                 zero_phase;
    logic [DEN_W-1:0]     den;

    logic                 en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exact_mode_reg   <= 1'b0;
            tiled_mode_reg   <= 1'b0;
            frame_width_reg  <= DIM_W'(4096);
            frame_height_reg <= DIM_W'(4096);
            tile_size_reg    <= DIM_W'(64);
            pitch_reg        <= PITCH_W'(8000);
            lambda_reg       <= LAMBDA_W'(633);
            focal_reg        <= FOCAL_W'(100000000);
        end
        else if (wr_en)
        begin
            case (reg_index_t'(wr_index))
                REG_EXACT_MODE:   exact_mode_reg   <= wr_data[0];
                REG_TILED_MODE:   tiled_mode_reg   <= wr_data[0];
                REG_FRAME_WIDTH:  frame_width_reg  <= wr_data[DIM_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= wr_data[DIM_W-1:0];
                REG_TILE_SIZE:    tile_size_reg    <= wr_data[DIM_W-1:0];
                REG_PIXEL_PITCH:  pitch_reg        <= wr_data[PITCH_W-1:0];
                REG_WAVELENGTH:   lambda_reg       <= wr_data[LAMBDA_W-1:0];
                REG_FOCAL_LENGTH: focal_reg        <= wr_data[FOCAL_W-1:0];
                default:          exact_mode_reg   <= exact_mode_reg;
            endcase
        end
    end

    // derived constants, settled long before any item needs them
    assign f2_next = focal_reg * focal_reg;
    assign fl_prod = focal_reg * lambda_reg;

    always_ff @(posedge clk)
    begin
        f2_reg  <= f2_next;
        fl2_reg <= {fl_prod, 1'b0};
    end

    always_comb
    begin
        width_c  = (frame_width_reg > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : frame_width_reg;
        height_c = (frame_height_reg > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : frame_height_reg;
        tile_c   = (tile_size_reg > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : tile_size_reg;
        if (tile_c == '0)
        begin
            tile_c = DIM_W'(1);
        end
        if (exact_mode_reg)
        begin
            zero_phase = (lambda_reg == '0);
            den        = {{(DEN_W - LAMBDA_W - SQRT_FRAC){1'b0}}, lambda_reg,
                          {SQRT_FRAC{1'b0}}};
        end
        else
        begin
            zero_phase = (lambda_reg == '0) || (focal_reg == '0);
            den        = fl2_reg;
        end
    end

    // pipeline advance
    assign en         = !result_valid || !result_stall;
    assign item_stall = !en;

    // ---------------- input and tile remainder ----------------
    logic [MOD_STAGES:0]               m_v_reg;
    logic [MOD_STAGES:0]               m_err_reg;
    logic [MOD_STAGES:0][COORD_W-1:0]  m_row_reg;
    logic [MOD_STAGES:0][COORD_W-1:0]  m_col_reg;
    logic [MOD_STAGES:0][DIM_W-1:0]    m_rr_reg;
    logic [MOD_STAGES:0][DIM_W-1:0]    m_rc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            m_v_reg[0] <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_row_reg[0] <= item.row;
            m_col_reg[0] <= item.col;
            m_rr_reg[0]  <= '0;
            m_rc_reg[0]  <= '0;
            m_err_reg[0] <= ({1'b0, item.col} >= width_c) || ({1'b0, item.row} >= height_c);
        end
    end

    for (genvar s = 0; s < MOD_STAGES; s++)
    begin : g_mod
        logic [DIM_W-1:0] rr_next;
        logic [DIM_W-1:0] rc_next;

        always_comb
        begin
            logic [DIM_W-1:0] tr;
            logic [DIM_W-1:0] tc;
            rr_next = m_rr_reg[s];
            rc_next = m_rc_reg[s];
            for (int b = 0; b < MOD_BITS; b++)
            begin
                tr = {rr_next[DIM_W-2:0], m_row_reg[s][COORD_W-1-(s*MOD_BITS+b)]};
                tc = {rc_next[DIM_W-2:0], m_col_reg[s][COORD_W-1-(s*MOD_BITS+b)]};
                if (tr >= tile_c)
                begin
                    tr = tr - tile_c;
                end
                if (tc >= tile_c)
                begin
                    tc = tc - tile_c;
                end
                rr_next = tr;
                rc_next = tc;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                m_v_reg[s+1] <= 1'b0;
            end
            else if (en)
            begin
                m_v_reg[s+1] <= m_v_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                m_row_reg[s+1] <= m_row_reg[s];
                m_col_reg[s+1] <= m_col_reg[s];
                m_err_reg[s+1] <= m_err_reg[s];
                m_rr_reg[s+1]  <= rr_next;
                m_rc_reg[s+1]  <= rc_next;
            end
        end
    end

    // ---------------- offsets, pitch, squares, radius ----------------
    logic                     o_v_reg, p_v_reg, q_v_reg, r_v_reg;
    logic                     o_err_reg, p_err_reg, q_err_reg, r_err_reg;
    logic signed [OFS_W-1:0]  o_dx_reg, o_dy_reg;
    logic signed [OFS_W-1:0]  o_dx_next, o_dy_next;
    logic signed [DX_W-1:0]   p_dx_reg, p_dy_reg;
    logic signed [DX_W:0]     p_dx_prod, p_dy_prod;
    logic [R2_W-1:0]          q_dx2_reg, q_dy2_reg;
    logic [2*DX_W-1:0]        q_dx2_prod, q_dy2_prod;
    logic [R2_W-1:0]          r_r2_reg;
    logic [N_W-1:0]           n_next;

    // square root stage 0 lives here
    logic [SQ_STEPS:0]              sq_v_reg;
    logic [SQ_STEPS:0]              sq_err_reg;
    logic [SQ_STEPS:0][N_W-1:0]     sq_n_reg;
    logic [SQ_STEPS:0][ROOT_W-1:0]  sq_root_reg;
    logic [SQ_STEPS:0][SQ_REM_W-1:0] sq_rem_reg;

    always_comb
    begin
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        logic [DIM_W-1:0]   cx;
        logic [DIM_W-1:0]   cy;
        if (tiled_mode_reg)
        begin
            px = m_rc_reg[MOD_STAGES][COORD_W-1:0];
            py = m_rr_reg[MOD_STAGES][COORD_W-1:0];
            cx = tile_c >> 1;
            cy = tile_c >> 1;
        end
        else
        begin
            px = m_col_reg[MOD_STAGES];
            py = m_row_reg[MOD_STAGES];
            cx = width_c >> 1;
            cy = height_c >> 1;
        end
        o_dx_next = $signed({2'b00, px}) - $signed({1'b0, cx});
        o_dy_next = $signed({2'b00, py}) - $signed({1'b0, cy});
    end

    assign p_dx_prod  = o_dx_reg * $signed({1'b0, pitch_reg});
    assign p_dy_prod  = o_dy_reg * $signed({1'b0, pitch_reg});
    assign q_dx2_prod = p_dx_reg * p_dx_reg;
    assign q_dy2_prod = p_dy_reg * p_dy_reg;
    assign n_next     = exact_mode_reg ? ({2'b00, r_r2_reg} + {2'b00, f2_reg})
                                       : {2'b00, r_r2_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_v_reg     <= 1'b0;
            p_v_reg     <= 1'b0;
            q_v_reg     <= 1'b0;
            r_v_reg     <= 1'b0;
            sq_v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            o_v_reg     <= m_v_reg[MOD_STAGES];
            p_v_reg     <= o_v_reg;
            q_v_reg     <= p_v_reg;
            r_v_reg     <= q_v_reg;
            sq_v_reg[0] <= r_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_err_reg <= m_err_reg[MOD_STAGES];
            o_dx_reg  <= o_dx_next;
            o_dy_reg  <= o_dy_next;
            p_err_reg <= o_err_reg;
            p_dx_reg  <= p_dx_prod[DX_W-1:0];
            p_dy_reg  <= p_dy_prod[DX_W-1:0];
            q_err_reg <= p_err_reg;
            q_dx2_reg <= q_dx2_prod[R2_W-1:0];
            q_dy2_reg <= q_dy2_prod[R2_W-1:0];
            r_err_reg <= q_err_reg;
            r_r2_reg  <= q_dx2_reg + q_dy2_reg;
            sq_err_reg[0]  <= r_err_reg;
            sq_n_reg[0]    <= n_next;
            sq_root_reg[0] <= '0;
            sq_rem_reg[0]  <= '0;
        end
    end

    // ---------------- square root, one digit per stage ----------------
    for (genvar j = 0; j < SQ_STEPS; j++)
    begin : g_sqrt
        localparam int K = SQ_STEPS - 1 - j;
        logic [1:0]          pair;
        logic [SQ_REM_W-1:0] rem_s;
        logic [SQ_REM_W-1:0] trial;
        logic                take;

        if (K >= SQRT_FRAC)
        begin : g_pair
            assign pair = sq_n_reg[j][2*(K-SQRT_FRAC) +: 2];
        end
        else
        begin : g_zero
            assign pair = 2'b00;
        end

        assign rem_s = {sq_rem_reg[j][SQ_REM_W-3:0], pair};
        assign trial = {1'b0, sq_root_reg[j], 2'b01};
        assign take  = (rem_s >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_v_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                sq_v_reg[j+1] <= sq_v_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_err_reg[j+1]  <= sq_err_reg[j];
                sq_n_reg[j+1]    <= sq_n_reg[j];
                sq_root_reg[j+1] <= {sq_root_reg[j][ROOT_W-2:0], take};
                sq_rem_reg[j+1]  <= take ? (rem_s - trial) : rem_s;
            end
        end
    end

    // ---------------- fractional divider ----------------
    logic [DIV_STEPS:0]              dv_v_reg;
    logic [DIV_STEPS:0]              dv_err_reg;
    logic [DIV_STEPS:0][NUM_W-1:0]   dv_num_reg;
    logic [DIV_STEPS:0][DEN_W-1:0]   dv_rem_reg;
    logic [DIV_STEPS:0][Q_W-1:0]     dv_q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            dv_v_reg[0] <= sq_v_reg[SQ_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_err_reg[0] <= sq_err_reg[SQ_STEPS];
            if (exact_mode_reg)
            begin
                dv_num_reg[0] <= {{(R2_W - ROOT_W){1'b0}}, sq_root_reg[SQ_STEPS], {Q_W{1'b0}}};
            end
            else
            begin
                dv_num_reg[0] <= {sq_n_reg[SQ_STEPS][R2_W-1:0], {Q_W{1'b0}}};
            end
            dv_rem_reg[0] <= '0;
            dv_q_reg[0]   <= '0;
        end
    end

    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        logic [DEN_W:0] rem_s;
        logic [DEN_W:0] diff;
        logic           take;

        assign rem_s = {dv_rem_reg[j], dv_num_reg[j][NUM_W-1]};
        assign diff  = rem_s - {1'b0, den};
        assign take  = (rem_s >= {1'b0, den});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_v_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                dv_v_reg[j+1] <= dv_v_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_err_reg[j+1] <= dv_err_reg[j];
                dv_num_reg[j+1] <= {dv_num_reg[j][NUM_W-2:0], 1'b0};
                dv_rem_reg[j+1] <= take ? diff[DEN_W-1:0] : rem_s[DEN_W-1:0];
                dv_q_reg[j+1]   <= {dv_q_reg[j][Q_W-2:0], take};
            end
        end
    end

    // ---------------- angle and CORDIC ----------------
    logic [CORDIC_STEPS:0]                 c_v_reg;
    logic [CORDIC_STEPS:0]                 c_err_reg;
    logic [CORDIC_STEPS:0][1:0]            c_quad_reg;
    logic [CORDIC_STEPS:0][CW-1:0]         c_x_reg;
    logic [CORDIC_STEPS:0][CW-1:0]         c_y_reg;
    logic [CORDIC_STEPS:0][ZW-1:0]         c_z_reg;
    logic [Q_W:0]                          q_round;
    logic [ANGLE_BITS-1:0]                 angle;

    always_comb
    begin
        q_round = {1'b0, dv_q_reg[DIV_STEPS]} + (Q_W+1)'(1);
        if (zero_phase)
        begin
            angle = '0;
        end
        else
        begin
            angle = ANGLE_BITS'(0) - q_round[ANGLE_BITS:1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            c_v_reg[0] <= dv_v_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_err_reg[0]  <= dv_err_reg[DIV_STEPS];
            c_quad_reg[0] <= angle[ANGLE_BITS-1 -: 2];
            c_x_reg[0]    <= CORDIC_GAIN_INV;
            c_y_reg[0]    <= '0;
            c_z_reg[0]    <= {2'b00, angle[ANGLE_BITS-3:0], {(ZW-ANGLE_BITS){1'b0}}};
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cordic
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;
        logic signed [CW-1:0] x_next;
        logic signed [CW-1:0] y_next;
        logic signed [ZW-1:0] z_next;

        always_comb
        begin
            xs = $signed(c_x_reg[i]) >>> i;
            ys = $signed(c_y_reg[i]) >>> i;
            if (!c_z_reg[i][ZW-1])
            begin
                x_next = $signed(c_x_reg[i]) - ys;
                y_next = $signed(c_y_reg[i]) + xs;
                z_next = $signed(c_z_reg[i]) - $signed(ATAN_TAB[i]);
            end
            else
            begin
                x_next = $signed(c_x_reg[i]) + ys;
                y_next = $signed(c_y_reg[i]) - xs;
                z_next = $signed(c_z_reg[i]) + $signed(ATAN_TAB[i]);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                c_v_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                c_v_reg[i+1] <= c_v_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                c_err_reg[i+1]  <= c_err_reg[i];
                c_quad_reg[i+1] <= c_quad_reg[i];
                c_x_reg[i+1]    <= x_next;
                c_y_reg[i+1]    <= y_next;
                c_z_reg[i+1]    <= z_next;
            end
        end
    end

    // ---------------- output register ----------------
    function automatic logic signed [OUT_W-1:0] to_out(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] r;
        r = (v + ROUND_HALF) >>> (30 - OUT_FRAC_BITS);
        if (r > OUT_LIM)
        begin
            r = OUT_LIM;
        end
        if (r < -OUT_LIM)
        begin
            r = -OUT_LIM;
        end
        return r[OUT_W-1:0];
    endfunction

    logic                    result_valid_reg;
    result_t                 result_reg;
    result_t                 result_next;

    always_comb
    begin
        logic signed [OUT_W-1:0] xc;
        logic signed [OUT_W-1:0] yc;
        xc = to_out($signed(c_x_reg[CORDIC_STEPS]));
        yc = to_out($signed(c_y_reg[CORDIC_STEPS]));
        case (c_quad_reg[CORDIC_STEPS])
            2'd0:
            begin
                result_next.real_part = xc;
                result_next.imag_part = yc;
            end
            2'd1:
            begin
                result_next.real_part = -yc;
                result_next.imag_part = xc;
            end
            2'd2:
            begin
                result_next.real_part = -xc;
                result_next.imag_part = -yc;
            end
            default:
            begin
                result_next.real_part = yc;
                result_next.imag_part = -xc;
            end
        endcase
        result_next.index_error = c_err_reg[CORDIC_STEPS];
        if (c_err_reg[CORDIC_STEPS])
        begin
            result_next.real_part = '0;
            result_next.imag_part = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            result_valid_reg <= c_v_reg[CORDIC_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

/* hdl/lpm_checker.sv */
// Port-level checker for the lens phase mask generator, bound to the top level.
// Depends on lpm_pkg.
`default_nettype none

module lpm_checker
    import lpm_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  wr_en,
    input wire logic [CFG_IDX_W-1:0]  wr_index,
    input wire logic [CFG_DATA_W-1:0] wr_data,
    input wire logic                  item_valid,
    input wire logic                  item_stall,
    input wire item_t                 item,
    input wire logic                  result_valid,
    input wire logic                  result_stall,
    input wire result_t               result
);

    // a blocked result holds
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result transfer changed");

    // input side only backs up behind a blocked result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid && result_stall)
        else $error("input stalled without a blocked result");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.index_error |->
            result.real_part == '0 && result.imag_part == '0)
        else $error("out-of-frame result carries non-zero parts");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |->
            result.real_part <= 16'sd16384 && result.real_part >= -16'sd16384 &&
            result.imag_part <= 16'sd16384 && result.imag_part >= -16'sd16384)
        else $error("result part outside unit range");

endmodule

bind lens_phase_mask_generator lpm_checker u_lpm_checker (.*);

`default_nettype wire
